@@ src/pid_step_filtered_derivative_clamp_assert.svh @@
// Assertion helpers for the controller RTL.
`ifndef PID_STEP_FILTERED_DERIVATIVE_CLAMP_ASSERT_SVH
`define PID_STEP_FILTERED_DERIVATIVE_CLAMP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PIDFD_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PIDFD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

@@ src/pidfd_pkg.sv @@
package pidfd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned ErrW    = 17;
  localparam int unsigned ErrSumW = 18;
  localparam int unsigned QW      = 32;
  localparam int unsigned SatW    = 51;
  localparam int unsigned AddrW   = 5;

  typedef logic signed [QW-1:0] q16_t;

  localparam q16_t Q16_MAX = 32'sh7fff_ffff;
  localparam q16_t Q16_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_GAIN_PROP       = 3'd0,
    REG_GAIN_INTEG_STEP = 3'd1,
    REG_GAIN_DERIV_STEP = 3'd2,
    REG_DERIV_POLE      = 3'd3,
    REG_INTEG_LOWER     = 3'd4,
    REG_INTEG_UPPER     = 3'd5
  } reg_idx_t;

  function automatic q16_t sat_q16(input logic signed [SatW-1:0] x);
    q16_t res;
    if (x > $signed({{(SatW-QW){1'b0}}, Q16_MAX})) begin
      res = Q16_MAX;
    end else if (x < $signed({{(SatW-QW){1'b1}}, Q16_MIN})) begin
      res = Q16_MIN;
    end else begin
      res = x[QW-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/pid_step_filtered_derivative_clamp.sv @@
// Fixed-point PID step: each input transaction carries a set point and a
// measurement; the block forms their difference, advances a trapezoidal
// integral clamped to [integ_lower, integ_upper] and a first-order filtered
// derivative, and returns one result transaction with the saturated Q16.16
// drive and a flag that is high when the integral sits on a clamp bound.
// One transaction is accepted every cycle unless the result side stalls;
// error, state update and output are registered in turn. The rate is set
// by the state update loop, one 32x32 filter multiply plus add and saturate
// per cycle. The user must write gains and bounds over the APB port at
// byte addresses 0x00 to 0x14 while the block is idle; it is not enforced.
module pid_step_filtered_derivative_clamp
  import pidfd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SampleW-1:0] in_target,
  input  logic signed [SampleW-1:0] in_sensed,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [QW-1:0]      out_drive,
  output logic                      out_integ_at_limit,

  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [AddrW-1:0]          paddr,
  input  logic [QW-1:0]             pwdata,
  output logic [QW-1:0]             prdata,
  output logic                      pready
);

  // Configuration registers
  q16_t gain_prop_r, gain_integ_step_r, gain_deriv_step_r, deriv_pole_r;
  q16_t integ_lower_r, integ_upper_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r       <= '0;
      gain_integ_step_r <= '0;
      gain_deriv_step_r <= '0;
      deriv_pole_r      <= '0;
      integ_lower_r     <= Q16_MIN;
      integ_upper_r     <= Q16_MAX;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[4:2]))
        REG_GAIN_PROP:       gain_prop_r       <= pwdata;
        REG_GAIN_INTEG_STEP: gain_integ_step_r <= pwdata;
        REG_GAIN_DERIV_STEP: gain_deriv_step_r <= pwdata;
        REG_DERIV_POLE:      deriv_pole_r      <= pwdata;
        REG_INTEG_LOWER:     integ_lower_r     <= pwdata;
        REG_INTEG_UPPER:     integ_upper_r     <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_GAIN_PROP:       prdata = gain_prop_r;
      REG_GAIN_INTEG_STEP: prdata = gain_integ_step_r;
      REG_GAIN_DERIV_STEP: prdata = gain_deriv_step_r;
      REG_DERIV_POLE:      prdata = deriv_pole_r;
      REG_INTEG_LOWER:     prdata = integ_lower_r;
      REG_INTEG_UPPER:     prdata = integ_upper_r;
      default:             prdata = '0;
    endcase
  end

  // Pipeline flow control: each stage takes a new transaction when it is
  // empty or its current one moves on.
  logic s1_vld_r, s2_vld_r, out_valid_r;
  logic out_free, s2_free, s1_free;
  logic in_acc, adv2, adv3;

  assign out_free = !out_valid_r || out_ready;
  assign s2_free  = !s2_vld_r || out_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && s1_free;
  assign adv2     = s1_vld_r && s2_free;
  assign adv3     = s2_vld_r && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv2) begin
        s1_vld_r <= 1'b0;
      end
      if (adv2) begin
        s2_vld_r <= 1'b1;
      end else if (adv3) begin
        s2_vld_r <= 1'b0;
      end
      if (adv3) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Stage 1: error
  logic signed [ErrW-1:0] err_nxt, err_r;

  assign err_nxt = {in_target[SampleW-1], in_target} - {in_sensed[SampleW-1], in_sensed};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      err_r <= err_nxt;
    end
  end

  // Stage 2: state update and proportional product
  logic signed [ErrW-1:0]    prev_error_r;
  q16_t                      integ_acc_r, deriv_acc_r;
  logic signed [48:0]        kpe_r, kpe_nxt;
  logic signed [ErrSumW-1:0] err_sum, err_diff;
  logic signed [49:0]        integ_prod, deriv_prod;
  logic signed [63:0]        pole_prod;
  logic signed [SatW-1:0]    integ_sum, deriv_sum, lower_x, upper_x;
  q16_t                      integ_nxt, deriv_nxt;

  assign err_sum    = {err_r[ErrW-1], err_r} + {prev_error_r[ErrW-1], prev_error_r};
  assign err_diff   = {err_r[ErrW-1], err_r} - {prev_error_r[ErrW-1], prev_error_r};
  assign integ_prod = gain_integ_step_r * err_sum;
  assign deriv_prod = gain_deriv_step_r * err_diff;
  assign pole_prod  = deriv_pole_r * deriv_acc_r;
  assign kpe_nxt    = gain_prop_r * err_r;

  assign integ_sum = {{(SatW-QW){integ_acc_r[QW-1]}}, integ_acc_r}
                   + {integ_prod[49], integ_prod};
  assign lower_x   = {{(SatW-QW){integ_lower_r[QW-1]}}, integ_lower_r};
  assign upper_x   = {{(SatW-QW){integ_upper_r[QW-1]}}, integ_upper_r};

  // When the bounds cross, a sum below the lower bound takes it; any other takes the upper bound.
  always_comb begin
    if (integ_sum < lower_x) begin
      integ_nxt = integ_lower_r;
    end else if (integ_sum > upper_x) begin
      integ_nxt = integ_upper_r;
    end else begin
      integ_nxt = integ_sum[QW-1:0];
    end
  end

  // Arithmetic shift right 16 of the filter product floors toward minus infinity.
  assign deriv_sum = {{3{pole_prod[63]}}, pole_prod[63:16]}
                   + {deriv_prod[49], deriv_prod};
  assign deriv_nxt = sat_q16(deriv_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_error_r <= '0;
      integ_acc_r  <= '0;
      deriv_acc_r  <= '0;
    end else if (adv2) begin
      prev_error_r <= err_r;
      integ_acc_r  <= integ_nxt;
      deriv_acc_r  <= deriv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      kpe_r <= kpe_nxt;
    end
  end

  // Stage 3: output sum and saturation
  logic signed [SatW-1:0] drive_sum;
  q16_t                   out_drive_r;
  logic                   out_at_limit_r;

  assign drive_sum = {{(SatW-49){kpe_r[48]}}, kpe_r}
                   + {{(SatW-QW){integ_acc_r[QW-1]}}, integ_acc_r}
                   + {{(SatW-QW){deriv_acc_r[QW-1]}}, deriv_acc_r};

  always_ff @(posedge clk) begin
    if (adv3) begin
      out_drive_r    <= sat_q16(drive_sum);
      out_at_limit_r <= (integ_acc_r == integ_lower_r) || (integ_acc_r == integ_upper_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive          = out_drive_r;
  assign out_integ_at_limit = out_at_limit_r;

`include "pid_step_filtered_derivative_clamp_assert.svh"

  `PIDFD_ASSERT_SAME(a_stall_means_full, clk, rst_n, !in_ready, s1_vld_r && s2_vld_r && out_valid_r)
  `PIDFD_ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, in_valid && in_ready, s1_vld_r)
  `PIDFD_ASSERT_NEXT(a_s1_moves_on, clk, rst_n, s1_vld_r && s2_free, s2_vld_r)
  `PIDFD_ASSERT_NEXT(a_s2_reaches_out, clk, rst_n, s2_vld_r && out_free, out_valid)

endmodule

@@ tb/sv/tb_pid_step_filtered_derivative_clamp.sv @@
`timescale 1ns / 1ps

module tb_pid_step_filtered_derivative_clamp;
  import pidfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 60;
  localparam int unsigned RAND_PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;
  // Register indexes past the end of the map; writes there must be dropped.
  localparam logic [2:0] SPARE_IDX_A = 3'd6;
  localparam logic [2:0] SPARE_IDX_B = 3'd7;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic signed [SampleW-1:0] in_target;
  logic signed [SampleW-1:0] in_sensed;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [QW-1:0]      out_drive;
  logic                      out_integ_at_limit;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [AddrW-1:0]          paddr;
  logic [QW-1:0]             pwdata;
  logic [QW-1:0]             prdata;
  logic                      pready;

  typedef struct {
    q16_t drive;
    logic at_limit;
  } drive_result_t;

  class drive_checker;
    q16_t kp, ki_step, kd_step, pole, integ_lo, integ_hi;
    int   err_prev;
    q16_t integ_state, deriv_state;
    drive_result_t expected_drives[$];
    int   errors;

    function new();
      kp          = '0;
      ki_step     = '0;
      kd_step     = '0;
      pole        = '0;
      integ_lo    = Q16_MIN;
      integ_hi    = Q16_MAX;
      err_prev    = 0;
      integ_state = '0;
      deriv_state = '0;
      errors      = 0;
    endfunction

    static function q16_t sat32(input longint x);
      if (x > longint'(Q16_MAX)) return Q16_MAX;
      if (x < longint'(Q16_MIN)) return Q16_MIN;
      return x[QW-1:0];
    endfunction

    function void write_reg(input logic [AddrW-1:0] addr, input logic [QW-1:0] data);
      case (addr[AddrW-1:2])
        REG_GAIN_PROP:       kp       = data;
        REG_GAIN_INTEG_STEP: ki_step  = data;
        REG_GAIN_DERIV_STEP: kd_step  = data;
        REG_DERIV_POLE:      pole     = data;
        REG_INTEG_LOWER:     integ_lo = data;
        REG_INTEG_UPPER:     integ_hi = data;
        default: ;
      endcase
    endfunction

    function void note_sample(input logic signed [SampleW-1:0] tgt,
                              input logic signed [SampleW-1:0] sns);
      longint        e, ep, isum, dsum, dsum_all, drv;
      drive_result_t res;
      e  = longint'(tgt) - longint'(sns);
      ep = longint'(err_prev);
      // Lower bound is tested first; with crossed bounds a sum below integ_lo takes integ_lo, any other integ_hi.
      isum = longint'(integ_state) + longint'(ki_step) * (e + ep);
      if (isum < longint'(integ_lo)) integ_state = integ_lo;
      else if (isum > longint'(integ_hi)) integ_state = integ_hi;
      else integ_state = isum[QW-1:0];
      dsum     = (longint'(pole) * longint'(deriv_state)) >>> 16;
      dsum_all = dsum + longint'(kd_step) * (e - ep);
      deriv_state = sat32(dsum_all);
      drv = longint'(kp) * e + longint'(integ_state) + longint'(deriv_state);
      err_prev = int'(e);
      res.drive    = sat32(drv);
      res.at_limit = (integ_state == integ_lo) || (integ_state == integ_hi);
      expected_drives.push_back(res);
    endfunction

    function void check_drive(input logic signed [QW-1:0] drive, input logic at_limit);
      drive_result_t exp_res;
      if (expected_drives.size() == 0) begin
        $error("unexpected result transaction: drive %0d integ_at_limit %0b",
               drive, at_limit);
        errors++;
        return;
      end
      exp_res = expected_drives.pop_front();
      if (drive !== exp_res.drive) begin
        $error("drive mismatch: expected %0d actual %0d", exp_res.drive, drive);
        errors++;
      end
      if (at_limit !== exp_res.at_limit) begin
        $error("integ_at_limit mismatch: expected %0b actual %0b",
               exp_res.at_limit, at_limit);
        errors++;
      end
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction
  endclass

  drive_checker board = new();

  bit          idle_on = 1'b1;
  bit          hold_out_request = 1'b0;
  int unsigned cycle_count = 0;

  pid_step_filtered_derivative_clamp i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_target          (in_target),
    .in_sensed          (in_sensed),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_drive          (out_drive),
    .out_integ_at_limit (out_integ_at_limit),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) board.write_reg(paddr, pwdata);
      if (in_valid && in_ready) board.note_sample(in_target, in_sensed);
      if (out_valid && out_ready) board.check_drive(out_drive, out_integ_at_limit);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out_request) begin
        hold_out_request = 1'b0;
        out_ready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [2:0] idx, input logic [QW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_gains(input q16_t g_p, input q16_t g_i, input q16_t g_d,
                           input q16_t g_pole, input q16_t lo, input q16_t hi);
    cfg_write(REG_GAIN_PROP, g_p);
    cfg_write(REG_GAIN_INTEG_STEP, g_i);
    cfg_write(REG_GAIN_DERIV_STEP, g_d);
    cfg_write(REG_DERIV_POLE, g_pole);
    cfg_write(REG_INTEG_LOWER, lo);
    cfg_write(REG_INTEG_UPPER, hi);
  endtask

  // Leaves valid high after the transaction; the caller drops it with drain_results.
  task automatic push_sample(input logic signed [SampleW-1:0] t,
                             input logic signed [SampleW-1:0] s);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid  = 1'b1;
    in_target = t;
    in_sensed = s;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic push_random_sample();
    logic signed [SampleW-1:0] t, s;
    int unsigned               sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      t = 16'($urandom);
      s = 16'($urandom);
    end else if (sel < 8) begin
      t = 16'($urandom);
      s = 16'(int'(t) + int'($urandom_range(0, 64)) - 32);
    end else begin
      t = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      s = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    push_sample(t, s);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic q16_t pick_q16(input int unsigned span);
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) return q16_t'($urandom);
    if (sel == 1) begin
      case ($urandom_range(0, 3))
        0:       return Q16_MAX;
        1:       return Q16_MIN;
        2:       return '0;
        default: return 32'sh0001_0000;
      endcase
    end
    return q16_t'(int'($urandom_range(0, 2 * span)) - int'(span));
  endfunction

  initial begin
    q16_t lo, hi, swap;
    in_valid  = 1'b0;
    in_target = '0;
    in_sensed = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    rst_n     = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Reset values: zero gains, widest bounds.
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh1234, -16'sh0567);
    drain_results();

    set_gains(32'sh0001_0000, 32'sh0000_4000, 32'sh0002_0000, 32'sh0000_8000,
              -32'sh0100_0000, 32'sh0100_0000);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh0000, 16'sh0000);
    push_sample(16'sh7fff, 16'sh7fff);
    push_sample(16'sh8000, 16'sh8000);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh0064, -16'sh0032);
    push_sample(-16'sh0001, 16'sh0001);
    push_sample(16'sh8000, 16'sh0000);
    push_sample(16'sh0000, 16'sh8000);
    drain_results();

    // Largest gains: saturate the derivative and the drive.
    set_gains(Q16_MAX, Q16_MAX, Q16_MIN, Q16_MAX, Q16_MIN, Q16_MAX);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh0000, 16'sh0000);
    push_sample(16'sh8000, 16'sh7fff);
    drain_results();

    // Crossed bounds: sums below the lower bound take it, all others the upper.
    set_gains(32'sh0001_0000, 32'sh0000_0100, 32'sh0001_0000, 32'sh0000_8000,
              32'sh0001_0000, -32'sh0001_0000);
    push_sample(16'sh000a, 16'sh0000);
    push_sample(16'sh0000, 16'sh000a);
    push_sample(16'sh0000, 16'sh0000);
    push_sample(-16'sh0005, 16'sh0005);
    drain_results();

    // Writes past the register map are dropped; equal bounds pin the flag.
    cfg_write(SPARE_IDX_A, 32'hdead_beef);
    cfg_write(SPARE_IDX_B, 32'h1357_9bdf);
    set_gains(Q16_MIN, Q16_MIN, Q16_MAX, Q16_MIN, '0, '0);
    push_sample(16'sh7fff, 16'sh8000);
    push_sample(16'sh8000, 16'sh7fff);
    push_sample(16'sh0001, 16'sh0000);
    push_sample(16'sh8000, 16'sh8000);
    drain_results();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      lo = pick_q16(32'h0100_0000);
      hi = pick_q16(32'h0100_0000);
      if ($urandom_range(0, 3) != 0 && lo > hi) begin
        swap = lo;
        lo   = hi;
        hi   = swap;
      end
      set_gains(pick_q16(32'h0004_0000), pick_q16(32'h0000_4000),
                pick_q16(32'h0004_0000), pick_q16(32'h0001_0000), lo, hi);
      if (ph == RAND_PHASES - 1) idle_on = 1'b0;
      // Long result hold-off: the block fills up and stalls its input.
      if (ph == 2) hold_out_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Sender pause until every pending result is back.
        if (ph == 4 && n == PHASE_ITEMS / 2) drain_results();
        push_random_sample();
      end
      drain_results();
    end

    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
